// ===== sv/eye_aspect_ratio_blink_assert.svh =====
// Assertion macros for the eye aspect ratio blink detector.
// Each macro takes a label, the clock, the active-low reset and the expressions to check.
`ifndef EYE_ASPECT_RATIO_BLINK_ASSERT_SVH
`define EYE_ASPECT_RATIO_BLINK_ASSERT_SVH

`ifndef NO_ASSERTIONS

// The expression must never hold outside reset.
`define EAR_ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("ear assertion failed: forbidden condition");

// The consequent must hold in the same cycle as the antecedent.
`define EAR_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ear assertion failed: implication");

// The consequent must hold in the cycle after the antecedent.
`define EAR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ear assertion failed: next-cycle implication");

`else

`define EAR_ASSERT_NEVER(label, clk, rst_n, expr)
`define EAR_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define EAR_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== sv/ear_pkg.sv =====
`timescale 1ns / 1ps

package ear_pkg;

    localparam int COORD_BITS_DEF = 12;

    localparam int NUM_POINTS = 12;
    localparam int EYE_POINTS = 6;
    localparam int PT_IDX_W   = $clog2(NUM_POINTS);
    localparam int CNT_W      = $clog2(NUM_POINTS + 1);

    // Q2.14 ratio format
    localparam int RATIO_BITS = 16;
    localparam int FRAC_BITS  = 14;
    // numerator >= den << OVF_SH means the quotient does not fit in RATIO_BITS
    localparam int DIV_SH     = RATIO_BITS - FRAC_BITS;
    localparam int OVF_SH     = DIV_SH + 1;

    localparam logic [RATIO_BITS-1:0] RATIO_MAX    = '1;
    localparam logic [RATIO_BITS-1:0] THRESH_RESET = 16'd3277;

    localparam int OUT_TDATA_W = ((3 * RATIO_BITS + 1 + 7) / 8) * 8;

    typedef logic [PT_IDX_W-1:0] t_pt_idx;

    typedef enum logic [1:0] {
        DIST_VA,
        DIST_VB,
        DIST_HC
    } t_dist;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD,
        S_DIFF,
        S_MULX,
        S_MULY,
        S_SQ_GO,
        S_SQ_RUN,
        S_DV_GO,
        S_DV_RUN,
        S_OUT
    } t_seq_state;

    typedef enum logic {
        MODE_SQRT,
        MODE_DIV
    } t_iter_mode;

    typedef struct packed {
        logic       start;
        t_iter_mode mode;
    } t_iter_cmd;

    // Store address of one end of a distance pair: p1-p5, p2-p4, p0-p3
    function automatic t_pt_idx pair_addr(logic eye, t_dist d, logic far_end);
        logic [2:0] off;
        unique case (d)
            DIST_VA: off = far_end ? 3'd5 : 3'd1;
            DIST_VB: off = far_end ? 3'd4 : 3'd2;
            DIST_HC: off = far_end ? 3'd3 : 3'd0;
            default: off = 3'd0;
        endcase
        return t_pt_idx'(off) + (eye ? t_pt_idx'(EYE_POINTS) : t_pt_idx'(0));
    endfunction

endpackage

// ===== sv/eye_aspect_ratio_blink.sv =====
`timescale 1ns / 1ps

// Eye aspect ratio blink detector. Feed twelve landmark points, one word each:
// six of the first eye, then six of the second, each in ring order p0..p5.
// s_axis_tuser marks a point that restarts loading as point zero; after twelve
// points the count wraps by itself. Each of the first eleven points is a write
// into the point store. The twelfth point starts the computation, during which
// s_axis_tready is low: for each eye, three Euclidean distances, each a store
// read, a difference, the shared multiplier squaring dx and then dy, a start
// step and a run of the shared compare-subtract unit over ROOT_BITS root bits
// (ROOT_BITS = COORD_BITS + 15), then one division of a start step and a run
// of the same unit over 16 quotient bits; then the result word is loaded.
// The load waits while an earlier result word is still waiting. The result word
// (both eye ratios and their mean, all Q2.14, and the blink flag) sits in an
// output register, so loading of the next set goes on while it waits.
// i_cfg_wr_en writes the blink threshold (reset 0.2); write it only while
// the block is idle.
`include "eye_aspect_ratio_blink_assert.svh"

module eye_aspect_ratio_blink #(
    parameter int COORD_BITS = ear_pkg::COORD_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,

    // point stream
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // tdata, lowest bit up: point_x, point_y, zero fill
    input  logic [((2*COORD_BITS+7)/8)*8-1:0]      s_axis_tdata,
    // tuser: first_point
    input  logic                                   s_axis_tuser,

    // result stream
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // tdata, lowest bit up: first_eye_ratio, second_eye_ratio,
    // average_ratio, blinking, zero fill
    output logic [ear_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,

    // blink threshold register
    input  logic                                   i_cfg_wr_en,
    input  logic [ear_pkg::RATIO_BITS-1:0]         i_cfg_wr_data
);

    import ear_pkg::*;

    // squared distance, radicand scaled by 2^28, root width, unit width
    localparam int S_W  = 2 * COORD_BITS + 1;
    localparam int SQ_W = S_W + 2 * FRAC_BITS;
    localparam int R_W  = (SQ_W + 1) / 2;
    localparam int U_W  = R_W + 2;
    localparam int F_W  = 2 * R_W;

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    t_seq_state           r_state, n_state;
    logic [CNT_W-1:0]     r_count, n_count;
    logic                 r_eye, n_eye;
    t_dist                r_dsel, n_dsel;
    logic [RATIO_BITS-1:0] r_thresh;
    logic                 r_out_valid;

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    logic [COORD_BITS-1:0] r_dx, r_dy;
    logic [S_W-1:0]        r_sum;
    logic [R_W-1:0]        r_da, r_db, r_dc;
    logic                  r_ovf;
    logic [RATIO_BITS-1:0] r_ratio0, r_ratio1;
    logic [OUT_TDATA_W-1:0] r_out_data;

    // ------------------------------------------------------------------
    // Input side: pick the store slot for the incoming point
    // ------------------------------------------------------------------
    logic             in_acc;
    logic [CNT_W-1:0] slot;
    logic             set_done;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        if (s_axis_tuser || (r_count >= CNT_W'(NUM_POINTS))) begin
            slot = '0;
        end else begin
            slot = r_count;
        end
        set_done = (slot == CNT_W'(NUM_POINTS - 1));
    end

    // ------------------------------------------------------------------
    // Point store: x in the low half, y in the high half
    // ------------------------------------------------------------------
    logic [2*COORD_BITS-1:0] rd_a, rd_b;
    t_pt_idx                 raddr_a, raddr_b;

    assign raddr_a = pair_addr(r_eye, r_dsel, 1'b0);
    assign raddr_b = pair_addr(r_eye, r_dsel, 1'b1);

    ear_ram #(
        .WIDTH (2 * COORD_BITS),
        .DEPTH (NUM_POINTS)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (in_acc),
        .i_waddr   (slot[PT_IDX_W-1:0]),
        .i_wdata   (s_axis_tdata[2*COORD_BITS-1:0]),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    // absolute coordinate differences of the pair just read
    logic [COORD_BITS-1:0] ax, ay, bx, by, abs_dx, abs_dy;

    always_comb begin
        ax = rd_a[COORD_BITS-1:0];
        ay = rd_a[2*COORD_BITS-1:COORD_BITS];
        bx = rd_b[COORD_BITS-1:0];
        by = rd_b[2*COORD_BITS-1:COORD_BITS];
        abs_dx = (ax >= bx) ? (ax - bx) : (bx - ax);
        abs_dy = (ay >= by) ? (ay - by) : (by - ay);
    end

    // one multiplier squares dx, then dy
    logic [COORD_BITS-1:0]   mul_op;
    logic [2*COORD_BITS-1:0] mul_p;

    assign mul_op = (r_state == S_MULY) ? r_dy : r_dx;
    assign mul_p  = mul_op * mul_op;

    // ------------------------------------------------------------------
    // Operands for the shared compare-subtract unit
    // ------------------------------------------------------------------
    t_iter_cmd            iter_cmd;
    logic                 iter_done;
    logic [R_W-1:0]       iter_acc;
    logic [R_W:0]         num_sum;
    logic [R_W+FRAC_BITS:0] num_full;
    logic [U_W-1:0]       iter_rem_init;
    logic [U_W-1:0]       iter_den;
    logic [F_W-1:0]       iter_feed;
    logic                 ovf;

    always_comb begin
        num_sum  = {1'b0, r_da} + {1'b0, r_db};
        num_full = {num_sum, {FRAC_BITS{1'b0}}};
        // quotient would not fit in 16 bits; also covers a zero horizontal distance
        ovf      = ((R_W + OVF_SH)'(num_sum) >= {r_dc, {OVF_SH{1'b0}}});
        iter_den = U_W'({r_dc, 1'b0});
        if (iter_cmd.mode == MODE_SQRT) begin
            iter_rem_init = '0;
            iter_feed     = F_W'({r_sum, {(2 * FRAC_BITS){1'b0}}});
        end else begin
            iter_rem_init = U_W'(num_sum >> DIV_SH);
            iter_feed     = {num_full[RATIO_BITS-1:0], {(F_W - RATIO_BITS){1'b0}}};
        end
    end

    ear_iter #(
        .ROOT_BITS (R_W)
    ) u_iter (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (iter_cmd),
        .i_rem_init  (iter_rem_init),
        .i_den       (iter_den),
        .i_feed_init (iter_feed),
        .o_done      (iter_done),
        .o_acc       (iter_acc)
    );

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        n_eye   = r_eye;
        n_dsel  = r_dsel;
        n_count = r_count;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_count = set_done ? '0 : (slot + CNT_W'(1));
                    if (set_done) begin
                        n_state = S_RD;
                        n_eye   = 1'b0;
                        n_dsel  = DIST_VA;
                    end
                end
            end
            S_RD:    n_state = S_DIFF;
            S_DIFF:  n_state = S_MULX;
            S_MULX:  n_state = S_MULY;
            S_MULY:  n_state = S_SQ_GO;
            S_SQ_GO: n_state = S_SQ_RUN;
            S_SQ_RUN: begin
                if (iter_done) begin
                    unique case (r_dsel)
                        DIST_VA: begin
                            n_dsel  = DIST_VB;
                            n_state = S_RD;
                        end
                        DIST_VB: begin
                            n_dsel  = DIST_HC;
                            n_state = S_RD;
                        end
                        default: n_state = S_DV_GO;
                    endcase
                end
            end
            S_DV_GO: n_state = S_DV_RUN;
            S_DV_RUN: begin
                if (iter_done) begin
                    n_dsel = DIST_VA;
                    if (r_eye) begin
                        n_state = S_OUT;
                    end else begin
                        n_eye   = 1'b1;
                        n_state = S_RD;
                    end
                end
            end
            S_OUT: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs
    // ------------------------------------------------------------------
    logic out_load;

    always_comb begin
        iter_cmd.start = 1'b0;
        iter_cmd.mode  = MODE_SQRT;
        out_load       = 1'b0;
        unique case (r_state)
            S_SQ_GO: begin
                iter_cmd.start = 1'b1;
                iter_cmd.mode  = MODE_SQRT;
            end
            S_DV_GO: begin
                iter_cmd.start = 1'b1;
                iter_cmd.mode  = MODE_DIV;
            end
            S_DV_RUN: iter_cmd.mode = MODE_DIV;
            S_OUT:    out_load = !r_out_valid || m_axis_tready;
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_eye       <= 1'b0;
            r_dsel      <= DIST_VA;
            r_thresh    <= THRESH_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_eye   <= n_eye;
            r_dsel  <= n_dsel;
            if (i_cfg_wr_en) begin
                r_thresh <= i_cfg_wr_data;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Datapath
    // ------------------------------------------------------------------
    logic [RATIO_BITS:0]   ratio_sum;
    logic [RATIO_BITS-1:0] avg;
    logic                  blink;

    always_comb begin
        ratio_sum = {1'b0, r_ratio0} + {1'b0, r_ratio1};
        avg       = ratio_sum[RATIO_BITS:1];
        blink     = (avg <= r_thresh);
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_DIFF: begin
                r_dx <= abs_dx;
                r_dy <= abs_dy;
            end
            S_MULX: r_sum <= S_W'(mul_p);
            S_MULY: r_sum <= r_sum + S_W'(mul_p);
            S_SQ_RUN: begin
                // store the finished distance in its slot
                if (iter_done) begin
                    case (r_dsel)
                        DIST_VA: r_da <= iter_acc;
                        DIST_VB: r_db <= iter_acc;
                        default: r_dc <= iter_acc;
                    endcase
                end
            end
            S_DV_GO: r_ovf <= ovf;
            S_DV_RUN: begin
                if (iter_done) begin
                    if (r_eye) begin
                        r_ratio1 <= r_ovf ? RATIO_MAX : iter_acc[RATIO_BITS-1:0];
                    end else begin
                        r_ratio0 <= r_ovf ? RATIO_MAX : iter_acc[RATIO_BITS-1:0];
                    end
                end
            end
            S_OUT: begin
                if (out_load) begin
                    r_out_data <= OUT_TDATA_W'({blink, avg, r_ratio1, r_ratio0});
                end
            end
            default: ;
        endcase
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // the shared unit only finishes while the sequencer waits for it
    `EAR_ASSERT_IMPLIES(a_done_in_run, i_clk, i_rst_n, iter_done,
        (r_state == S_SQ_RUN) || (r_state == S_DV_RUN))
    // the twelfth point starts the computation and wraps the count
    `EAR_ASSERT_NEXT(a_set_start, i_clk, i_rst_n, in_acc && set_done,
        (r_state == S_RD) && (r_count == '0) && !s_axis_tready)
    // the point count never reaches a full set
    `EAR_ASSERT_NEVER(a_count_range, i_clk, i_rst_n, r_count >= CNT_W'(NUM_POINTS))

endmodule

// ===== sv/ear_ram.sv =====
`timescale 1ns / 1ps

module ear_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 12
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

// ===== sv/ear_iter.sv =====
`timescale 1ns / 1ps

// Shared compare-subtract unit: restoring square root (two bits a step)
// or restoring division (one bit a step).
module ear_iter #(
    parameter int ROOT_BITS = 27
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  ear_pkg::t_iter_cmd     i_cmd,
    input  logic [ROOT_BITS+1:0]   i_rem_init,
    input  logic [ROOT_BITS+1:0]   i_den,
    input  logic [2*ROOT_BITS-1:0] i_feed_init,
    output logic                   o_done,
    output logic [ROOT_BITS-1:0]   o_acc
);

    import ear_pkg::*;

    localparam int U_W = ROOT_BITS + 2;
    localparam int F_W = 2 * ROOT_BITS;
    localparam int C_W = $clog2(ROOT_BITS + 1);

    logic             r_busy;
    logic             r_done;
    t_iter_mode       r_mode;
    logic [C_W-1:0]   r_cnt;
    logic [U_W-1:0]   r_rem;
    logic [U_W-1:0]   r_den;
    logic [ROOT_BITS-1:0] r_acc;
    logic [F_W-1:0]   r_feed;

    logic [U_W-1:0]   rem_sh;
    logic [U_W-1:0]   trial;
    logic             ge;
    logic [U_W-1:0]   n_rem;
    logic [ROOT_BITS-1:0] n_acc;
    logic [F_W-1:0]   n_feed;
    logic             last;

    always_comb begin
        if (r_mode == MODE_SQRT) begin
            rem_sh = {r_rem[U_W-3:0], r_feed[F_W-1 -: 2]};
            trial  = {r_acc, 2'b01};
            n_feed = {r_feed[F_W-3:0], 2'b00};
        end else begin
            rem_sh = {r_rem[U_W-2:0], r_feed[F_W-1]};
            trial  = r_den;
            n_feed = {r_feed[F_W-2:0], 1'b0};
        end
        ge    = (rem_sh >= trial);
        n_rem = ge ? (rem_sh - trial) : rem_sh;
        n_acc = {r_acc[ROOT_BITS-2:0], ge};
        last  = (r_cnt == C_W'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_mode <= MODE_SQRT;
        end else if (i_cmd.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_mode <= i_cmd.mode;
            r_cnt  <= (i_cmd.mode == MODE_SQRT) ? C_W'(ROOT_BITS) : C_W'(RATIO_BITS);
        end else if (r_busy) begin
            r_cnt <= r_cnt - C_W'(1);
            if (last) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_rem  <= i_rem_init;
            r_den  <= i_den;
            r_feed <= i_feed_init;
            r_acc  <= '0;
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_acc  <= n_acc;
            r_feed <= n_feed;
        end
    end

    assign o_done = r_done;
    assign o_acc  = r_acc;

endmodule
